[rtl/slc_pkg.sv]
// package with shared types and constants of the cache lookup block
`timescale 1ns / 1ps
`default_nettype none
package slc_pkg;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 30;
    localparam int RANK_W     = 3;
    localparam int CNT_W      = 32;
    localparam int VIDX_W     = 10;
    localparam int IB_W       = 4;
    localparam int OB_W       = 3;
    localparam int WCFG_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int RECIP_SH   = 20;
    localparam int RECIP_W    = RECIP_SH + 1;

    localparam logic [IB_W-1:0]   IDX_BITS_MAX = 4'd10;
    localparam logic [OB_W-1:0]   OFS_BITS_MIN = 3'd2;
    localparam logic [RANK_W-1:0] RANK_MAX     = 3'd7;

    localparam logic [IB_W-1:0]   RST_INDEX_BITS  = 4'd10;
    localparam logic [OB_W-1:0]   RST_OFFSET_BITS = 3'd2;
    localparam logic [WCFG_W-1:0] RST_WAYS_IN_USE = 4'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SET,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic mul1;
        logic mul2;
        logic set_rd;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/slc_ifs.sv]
// channel interfaces: lookup request, lookup result and configuration write
`timescale 1ns / 1ps
`default_nettype none
interface slc_req_if;
    import slc_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface slc_rsp_if;
    import slc_pkg::*;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [2:0]       way_used;
    logic             evicted;
    logic [CNT_W-1:0] access_total;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    modport source (output valid, output hit, output way_used, output evicted,
                    output access_total, output hit_total, output miss_total,
                    input ready);
    modport sink   (input valid, input hit, input way_used, input evicted,
                    input access_total, input hit_total, input miss_total,
                    output ready);
endinterface

interface slc_cfg_if;
    import slc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/slc_ctrl.sv]
// controller state machine sequencing clear pass, set computation and update
`timescale 1ns / 1ps
`default_nettype none
module slc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output slc_pkg::t_ctrl_cmd   o_cmd,
    input  slc_pkg::t_dp_sts     i_sts
);
    import slc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_SET;
            end
            ST_SET: begin
                o_cmd.set_rd = 1'b1;
                n_state      = ST_UPD;
            end
            ST_UPD: begin
                // hold the read row until the result register can take the result
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/slc_dp.sv]
// datapath: config registers, set arithmetic, line memories, lru update, counters
`timescale 1ns / 1ps
`default_nettype none
module slc_dp #(
    parameter int MAX_SETS = 1024,
    parameter int MAX_WAYS = 8
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire [slc_pkg::ADDR_W-1:0]  i_address,
    slc_cfg_if.sink                    i_cfg,
    slc_rsp_if.source                  o_rsp,
    input  slc_pkg::t_ctrl_cmd         i_cmd,
    output slc_pkg::t_dp_sts           o_sts
);
    import slc_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int MSET_W = $clog2(MAX_SETS + 1);
    localparam int REM_W  = VIDX_W + MSET_W;
    localparam int PROD_W = VIDX_W + RECIP_W;
    localparam int WSEL_W = 5;
    localparam int LANE_W = RANK_W + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((33'd1 << RECIP_SH) / MAX_SETS);

    // configuration registers
    logic [IB_W-1:0]   r_index_bits;
    logic [OB_W-1:0]   r_offset_bits;
    logic [WCFG_W-1:0] r_ways_in_use;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits  <= RST_INDEX_BITS;
            r_offset_bits <= RST_OFFSET_BITS;
            r_ways_in_use <= RST_WAYS_IN_USE;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_INDEX_BITS) begin
                r_index_bits <= i_cfg.data[IB_W-1:0];
            end
            if (i_cfg.index == CFG_OFFSET_BITS) begin
                r_offset_bits <= i_cfg.data[OB_W-1:0];
            end
            if (i_cfg.index == CFG_WAYS_IN_USE) begin
                r_ways_in_use <= i_cfg.data[WCFG_W-1:0];
            end
        end
    end

    // address split
    logic [IB_W-1:0]   ib;
    logic [OB_W-1:0]   ob;
    logic [WSEL_W-1:0] ways;
    logic [VIDX_W:0]   idx_mask;
    logic [ADDR_W-1:0] addr_sh;
    logic [ADDR_W-1:0] tag_sh;

    assign ib       = (r_index_bits > IDX_BITS_MAX) ? IDX_BITS_MAX : r_index_bits;
    assign ob       = (r_offset_bits < OFS_BITS_MIN) ? OFS_BITS_MIN : r_offset_bits;
    assign idx_mask = (VIDX_W + 1)'((12'd1 << ib) - 12'd1);
    assign addr_sh  = i_address >> ob;
    assign tag_sh   = i_address >> (WSEL_W'(ob) + WSEL_W'(ib));

    always_comb begin
        if (r_ways_in_use == '0) begin
            ways = WSEL_W'(1);
        end else if ({1'b0, r_ways_in_use} > WSEL_W'(MAX_WAYS)) begin
            ways = WSEL_W'(MAX_WAYS);
        end else begin
            ways = {1'b0, r_ways_in_use};
        end
    end

    logic [VIDX_W-1:0]   r_v;
    logic [TAG_W-1:0]    r_tag;
    logic [MAX_WAYS-1:0] r_srch;
    logic [PROD_W-1:0]   r_prod;
    logic [VIDX_W-1:0]   r_qm;
    logic [VIDX_W-1:0]   quo;
    logic [VIDX_W+MSET_W-1:0] qm_full;

    assign quo     = VIDX_W'(r_prod >> RECIP_SH);
    assign qm_full = quo * MSET_W'(MAX_SETS);

    // set number modulo the set count by reciprocal, quotient low by at most one
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_v   <= addr_sh[VIDX_W-1:0] & idx_mask[VIDX_W-1:0];
            r_tag <= tag_sh[TAG_W-1:0];
            for (int k = 0; k < MAX_WAYS; k++) begin
                r_srch[k] <= (WSEL_W'(k) < ways);
            end
        end
        if (i_cmd.mul1) begin
            r_prod <= r_v * RECIP;
        end
        if (i_cmd.mul2) begin
            r_qm <= VIDX_W'(qm_full);
        end
    end

    logic [REM_W-1:0] rem;
    logic [SET_W-1:0] set_idx;

    always_comb begin
        rem = REM_W'(r_v - r_qm);
        if (rem >= REM_W'(MAX_SETS)) begin
            rem = rem - REM_W'(MAX_SETS);
        end
        set_idx = SET_W'(rem);
    end

    // clear pass counter
    logic [SET_W-1:0] r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign o_sts.clr_last = (r_clr == SET_W'(MAX_SETS - 1));

    // line memories: valid and rank per way in one, tags in the other
    logic [MAX_WAYS*LANE_W-1:0] vr_mem  [MAX_SETS];
    logic [MAX_WAYS*TAG_W-1:0]  tag_mem [MAX_SETS];
    logic [MAX_WAYS*LANE_W-1:0] r_vr_rd;
    logic [MAX_WAYS*TAG_W-1:0]  r_tag_rd;
    logic [SET_W-1:0]           r_set;
    logic [MAX_WAYS*LANE_W-1:0] n_vr_row;
    logic [MAX_WAYS*TAG_W-1:0]  n_tag_row;
    logic                       lk_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_rd) begin
            r_vr_rd  <= vr_mem[set_idx];
            r_tag_rd <= tag_mem[set_idx];
            r_set    <= set_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            vr_mem[r_clr] <= '0;
        end else if (i_cmd.commit) begin
            vr_mem[r_set] <= n_vr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !lk_hit) begin
            tag_mem[r_set] <= n_tag_row;
        end
    end

    // lookup and recency update on the read row
    logic [MAX_WAYS-1:0] rd_valid;
    logic [RANK_W-1:0]   rd_rank [MAX_WAYS];
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] free_vec;
    logic [MAX_WAYS-1:0] vict_vec;
    logic [(1<<RANK_W)-1:0] lvl_any;
    logic [RANK_W-1:0]   top_rank;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    vict_way;
    logic [WAY_W-1:0]    lk_way;
    logic                lk_free;
    logic [RANK_W:0]     old_rank;

    always_comb begin
        for (int k = 0; k < MAX_WAYS; k++) begin
            rd_valid[k] = r_vr_rd[k*LANE_W];
            rd_rank[k]  = r_vr_rd[k*LANE_W+1 +: RANK_W];
            hit_vec[k]  = r_srch[k] && rd_valid[k]
                          && (r_tag_rd[k*TAG_W +: TAG_W] == r_tag);
            free_vec[k] = r_srch[k] && !rd_valid[k];
        end
    end

    always_comb begin
        for (int v = 0; v < (1 << RANK_W); v++) begin
            lvl_any[v] = 1'b0;
            for (int k = 0; k < MAX_WAYS; k++) begin
                if (r_srch[k] && (rd_rank[k] == RANK_W'(v))) begin
                    lvl_any[v] = 1'b1;
                end
            end
        end
        top_rank = '0;
        for (int v = 0; v < (1 << RANK_W); v++) begin
            if (lvl_any[v]) begin
                top_rank = RANK_W'(v);
            end
        end
        for (int k = 0; k < MAX_WAYS; k++) begin
            vict_vec[k] = r_srch[k] && (rd_rank[k] == top_rank);
        end
    end

    // lowest way wins in each search
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        vict_way = '0;
        for (int k = MAX_WAYS - 1; k >= 0; k--) begin
            if (hit_vec[k]) begin
                hit_way = WAY_W'(k);
            end
            if (free_vec[k]) begin
                free_way = WAY_W'(k);
            end
            if (vict_vec[k]) begin
                vict_way = WAY_W'(k);
            end
        end
    end

    assign lk_hit  = |hit_vec;
    assign lk_free = |free_vec;

    always_comb begin
        if (lk_hit) begin
            lk_way = hit_way;
        end else if (lk_free) begin
            lk_way = free_way;
        end else begin
            lk_way = vict_way;
        end
    end

    always_comb begin
        // an invalid line counts as older than every rank
        old_rank = {1'b1, {RANK_W{1'b0}}};
        for (int k = 0; k < MAX_WAYS; k++) begin
            if ((WAY_W'(k) == lk_way) && rd_valid[k]) begin
                old_rank = {1'b0, rd_rank[k]};
            end
        end
    end

    always_comb begin
        n_vr_row  = r_vr_rd;
        n_tag_row = r_tag_rd;
        for (int k = 0; k < MAX_WAYS; k++) begin
            if (WAY_W'(k) == lk_way) begin
                n_vr_row[k*LANE_W +: LANE_W] = {{RANK_W{1'b0}}, 1'b1};
                n_tag_row[k*TAG_W +: TAG_W]  = r_tag;
            end else if (r_srch[k] && rd_valid[k] && ({1'b0, rd_rank[k]} < old_rank)
                         && (rd_rank[k] < RANK_MAX)) begin
                n_vr_row[k*LANE_W+1 +: RANK_W] = rd_rank[k] + 1'b1;
            end
        end
    end

    // statistics counters and result register
    logic [CNT_W-1:0] r_lookups;
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] n_lookups;
    logic [CNT_W-1:0] n_hits;
    logic [CNT_W-1:0] n_misses;
    logic             r_out_valid;
    logic             r_out_hit;
    logic [2:0]       r_out_way;
    logic             r_out_evicted;
    logic [WAY_W+2:0] way_ext;

    assign n_lookups = (r_lookups == '1) ? r_lookups : r_lookups + 1'b1;
    assign n_hits    = (lk_hit && (r_hits != '1)) ? r_hits + 1'b1 : r_hits;
    assign n_misses  = (!lk_hit && (r_misses != '1)) ? r_misses + 1'b1 : r_misses;
    assign way_ext   = (WAY_W + 3)'(lk_way);

    assign o_sts.out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookups   <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_lookups   <= n_lookups;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit     <= lk_hit;
            r_out_way     <= way_ext[2:0];
            r_out_evicted <= !lk_hit && !lk_free;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.way_used     = r_out_way;
    assign o_rsp.evicted      = r_out_evicted;
    assign o_rsp.access_total = r_lookups;
    assign o_rsp.hit_total    = r_hits;
    assign o_rsp.miss_total   = r_misses;

endmodule
`default_nettype wire

[rtl/set_assoc_lru_cache_lookup_core.sv]
// top level of the set-associative lru cache lookup block
// the result is registered after capture, ST_MUL1, ST_MUL2, ST_SET and the commit in ST_UPD;
//   the commit waits until the result register is free, and no new lookup is taken before it,
//   as each one runs the modulo multiplies and one registered read then write-back of the set row
// reset: after i_rst_n the valid/rank memory is cleared one set per cycle,
//   with input ready low; configuration writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_cache_lookup_core #(
    parameter int MAX_SETS = 1024,
    parameter int MAX_WAYS = 8
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    slc_req_if.sink   i_req,
    slc_rsp_if.source o_rsp,
    slc_cfg_if.sink   i_cfg
);
    import slc_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_sts   sts;
    logic      in_ready;

    assign i_req.ready = in_ready;

    slc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    slc_dp #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_address (i_req.address),
        .i_cfg     (i_cfg),
        .o_rsp     (o_rsp),
        .i_cmd     (cmd),
        .o_sts     (sts)
    );

    // one lookup in flight at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && in_ready) |=> !in_ready)
        else $error("input accepted while a lookup is in flight");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result committed over an untaken result");

    a_rise_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(cmd.commit))
        else $error("result valid without a commit");

    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_wr |-> (!cmd.commit && !in_ready))
        else $error("lookup activity during the clear pass");

endmodule
`default_nettype wire
